// File: hw/rtl/hps_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the heading PID step block.
// Used by every module under hw/rtl; depends on nothing else.
package hps_pkg;

	// Field widths
	localparam int ANGLE_W  = 24;
	localparam int ERR_W    = ANGLE_W + 1;
	localparam int DERIV_W  = ERR_W + 1;
	localparam int SUM_W    = 40;
	localparam int STEP_W   = 16;
	localparam int GAIN_W   = 20;
	localparam int DRIVE_W  = 16;
	localparam int CLAMP_W  = 15;
	localparam int ZONE_W   = 23;

	// Fixed-point scaling: drive is in 1/256 V
	localparam int ANGLE_FRAC_BITS = 8;
	localparam int GAIN_FRAC_BITS  = 16;
	localparam int DRIVE_FRAC_BITS = 8;
	localparam int DRIVE_SHIFT     = ANGLE_FRAC_BITS + GAIN_FRAC_BITS - DRIVE_FRAC_BITS;

	// Integral product is split into a low unsigned and a high signed part
	localparam int SPLIT_W = 20;
	localparam int HI_W    = SUM_W - SPLIT_W;
	localparam int PE_W    = ERR_W + GAIN_W + 1;
	localparam int PD_W    = DERIV_W + GAIN_W + 1;
	localparam int PL_W    = SPLIT_W + GAIN_W + 2;
	localparam int PH_W    = HI_W + GAIN_W + 1;
	localparam int P_W     = 62;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROP_GAIN  = 3'd0,
		REG_INTEG_GAIN = 3'd1,
		REG_DERIV_GAIN = 3'd2,
		REG_MAX_DRIVE  = 3'd3,
		REG_INTEG_ZONE = 3'd4,
		REG_TOLERANCE  = 3'd5,
		REG_STEP_LIMIT = 3'd6
	} cfg_reg_t;

	// Register reset values
	localparam logic [GAIN_W-1:0]  RST_PROP_GAIN  = 20'd10682;
	localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN = 20'd1049;
	localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN = 20'd10486;
	localparam logic [CLAMP_W-1:0] RST_MAX_DRIVE  = 15'd1792;
	localparam logic [ZONE_W-1:0]  RST_INTEG_ZONE = 23'd3840;
	localparam logic [ZONE_W-1:0]  RST_TOLERANCE  = 23'd154;
	localparam logic [STEP_W-1:0]  RST_STEP_LIMIT = 16'd300;

	// Integral saturation limits
	localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	typedef struct packed {
		logic [GAIN_W-1:0]  prop_gain;
		logic [GAIN_W-1:0]  integ_gain;
		logic [GAIN_W-1:0]  deriv_gain;
		logic [CLAMP_W-1:0] max_drive;
		logic [ZONE_W-1:0]  integ_zone;
		logic [ZONE_W-1:0]  tolerance;
		logic [STEP_W-1:0]  step_limit;
	} cfg_t;

	typedef struct packed {
		logic [ANGLE_W-1:0] measured_angle;
		logic [ANGLE_W-1:0] target_angle;
		logic               restart;
	} in_beat_t;

	// Result of the state update stage
	typedef struct packed {
		logic               active;
		logic               done;
		logic [STEP_W-1:0]  steps;
		logic [ERR_W-1:0]   err;
		logic [DERIV_W-1:0] deriv;
		logic [SUM_W-1:0]   sum;
	} step_t;

	// Partial products
	typedef struct packed {
		logic              active;
		logic              done;
		logic [STEP_W-1:0] steps;
		logic [PE_W-1:0]   pe;
		logic [PD_W-1:0]   pd;
		logic [PL_W-1:0]   pl;
		logic [PH_W-1:0]   ph;
	} prod_t;

	// Result beat
	typedef struct packed {
		logic [DRIVE_W-1:0] drive;
		logic               done;
		logic [STEP_W-1:0]  steps;
	} res_t;

endpackage

// File: hw/rtl/hps_state.sv
`timescale 1ns / 1ps
// Controller state and per-sample update: error, derivative, zoned integral.
// Depends on hps_pkg.
module hps_state (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s1_valid,
	input  hps_pkg::in_beat_t s1,
	input  hps_pkg::cfg_t    cfg,
	output logic             s2_valid,
	output hps_pkg::step_t   s2
);

	logic signed [hps_pkg::ERR_W-1:0] last_err_q;
	logic signed [hps_pkg::SUM_W-1:0] sum_q;
	logic [hps_pkg::STEP_W-1:0]       cnt_q;
	logic                             fin_q;

	logic signed [hps_pkg::ERR_W-1:0]   le_e;
	logic signed [hps_pkg::SUM_W-1:0]   sum_e;
	logic [hps_pkg::STEP_W-1:0]         cnt_e;
	logic                               fin_e;
	logic signed [hps_pkg::ERR_W-1:0]   err;
	logic [hps_pkg::ERR_W-1:0]          aerr;
	logic signed [hps_pkg::DERIV_W-1:0] deriv;
	logic signed [hps_pkg::SUM_W:0]     sum_ext;
	logic signed [hps_pkg::SUM_W-1:0]   sum_acc;
	logic                               stop;
	logic                               in_zone;

	logic signed [hps_pkg::ERR_W-1:0]   le_n;
	logic signed [hps_pkg::SUM_W-1:0]   sum_n;
	logic [hps_pkg::STEP_W-1:0]         cnt_n;
	logic                               fin_n;
	logic                               active;

	// Restart clears the state seen by this sample
	always_comb begin
		if (s1.restart) begin
			le_e  = '0;
			sum_e = '0;
			cnt_e = '0;
			fin_e = 1'b0;
		end else begin
			le_e  = last_err_q;
			sum_e = sum_q;
			cnt_e = cnt_q;
			fin_e = fin_q;
		end
	end

	// Error, magnitude, derivative and saturating accumulate
	always_comb begin
		err     = $signed({s1.target_angle[hps_pkg::ANGLE_W-1], s1.target_angle})
		        - $signed({s1.measured_angle[hps_pkg::ANGLE_W-1], s1.measured_angle});
		aerr    = err[hps_pkg::ERR_W-1] ? (~err + 1'b1) : err;
		stop    = (aerr <= {2'b00, cfg.tolerance}) || (cnt_e >= cfg.step_limit);
		in_zone = (aerr < {2'b00, cfg.integ_zone}) && (err != '0);
		deriv   = $signed({err[hps_pkg::ERR_W-1], err}) - $signed({le_e[hps_pkg::ERR_W-1], le_e});
		sum_ext = $signed({sum_e[hps_pkg::SUM_W-1], sum_e})
		        + $signed({{(hps_pkg::SUM_W+1-hps_pkg::ERR_W){err[hps_pkg::ERR_W-1]}}, err});
		if (sum_ext[hps_pkg::SUM_W] != sum_ext[hps_pkg::SUM_W-1]) begin
			sum_acc = sum_ext[hps_pkg::SUM_W] ? hps_pkg::SUM_MIN : hps_pkg::SUM_MAX;
		end else begin
			sum_acc = sum_ext[hps_pkg::SUM_W-1:0];
		end
	end

	// Next state: hold when latched done, finish on tolerance or step limit
	always_comb begin
		le_n   = le_e;
		sum_n  = sum_e;
		cnt_n  = cnt_e;
		fin_n  = fin_e;
		active = 1'b0;
		if (!fin_e) begin
			if (stop) begin
				fin_n = 1'b1;
			end else begin
				active = 1'b1;
				cnt_n  = cnt_e + 1'b1;
				le_n   = err;
				sum_n  = in_zone ? sum_acc : '0;
			end
		end
	end

	// Commit the state on each beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q <= '0;
			sum_q      <= '0;
			cnt_q      <= '0;
			fin_q      <= 1'b0;
			s2_valid   <= 1'b0;
		end else begin
			s2_valid <= s1_valid;
			if (s1_valid) begin
				last_err_q <= le_n;
				sum_q      <= sum_n;
				cnt_q      <= cnt_n;
				fin_q      <= fin_n;
			end
		end
	end

	// Stage payload for the multipliers
	always_ff @(posedge clk) begin
		if (s1_valid) begin
			s2.active <= active;
			s2.done   <= fin_n;
			s2.steps  <= cnt_n;
			s2.err    <= err;
			s2.deriv  <= deriv;
			s2.sum    <= sum_n;
		end
	end

endmodule

// File: hw/rtl/hps_mult.sv
`timescale 1ns / 1ps
// Gain products for the P, D and split I terms, one register stage.
// Depends on hps_pkg.
module hps_mult (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s2_valid,
	input  hps_pkg::step_t s2,
	input  hps_pkg::cfg_t  cfg,
	output logic           s3_valid,
	output hps_pkg::prod_t s3
);

	logic signed [hps_pkg::GAIN_W:0]  kp;
	logic signed [hps_pkg::GAIN_W:0]  ki;
	logic signed [hps_pkg::GAIN_W:0]  kd;
	logic signed [hps_pkg::SPLIT_W:0] sum_lo;
	logic signed [hps_pkg::HI_W-1:0]  sum_hi;
	logic signed [hps_pkg::PE_W-1:0]  pe;
	logic signed [hps_pkg::PD_W-1:0]  pd;
	logic signed [hps_pkg::PL_W-1:0]  pl;
	logic signed [hps_pkg::PH_W-1:0]  ph;

	// Gains are unsigned; give them a zero sign bit
	always_comb begin
		kp     = $signed({1'b0, cfg.prop_gain});
		ki     = $signed({1'b0, cfg.integ_gain});
		kd     = $signed({1'b0, cfg.deriv_gain});
		sum_lo = $signed({1'b0, s2.sum[hps_pkg::SPLIT_W-1:0]});
		sum_hi = $signed(s2.sum[hps_pkg::SUM_W-1:hps_pkg::SPLIT_W]);
		pe     = $signed(s2.err) * kp;
		pd     = $signed(s2.deriv) * kd;
		pl     = sum_lo * ki;
		ph     = sum_hi * ki;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_valid <= 1'b0;
		end else begin
			s3_valid <= s2_valid;
		end
	end

	// Register the products
	always_ff @(posedge clk) begin
		if (s2_valid) begin
			s3.active <= s2.active;
			s3.done   <= s2.done;
			s3.steps  <= s2.steps;
			s3.pe     <= pe;
			s3.pd     <= pd;
			s3.pl     <= pl;
			s3.ph     <= ph;
		end
	end

endmodule

// File: hw/rtl/hps_sum.sv
`timescale 1ns / 1ps
// PID sum register, then truncating scale, magnitude clamp and brake gating.
// Depends on hps_pkg.
module hps_sum (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s3_valid,
	input  hps_pkg::prod_t s3,
	input  hps_pkg::cfg_t  cfg,
	output logic           res_valid,
	output hps_pkg::res_t  res
);

	logic signed [hps_pkg::P_W-1:0] p;
	logic signed [hps_pkg::P_W-1:0] p_s4;
	logic                           active_s4;
	logic                           done_s4;
	logic [hps_pkg::STEP_W-1:0]     steps_s4;

	logic [hps_pkg::P_W-1:0]        mag;
	logic [hps_pkg::P_W-1:0]        mag_sh;
	logic [hps_pkg::CLAMP_W-1:0]    mag_cl;
	logic [hps_pkg::DRIVE_W-1:0]    drv;

	// Add the four partial products, high integral part weighted by 2^SPLIT_W
	always_comb begin
		p = $signed({{(hps_pkg::P_W-hps_pkg::PE_W){s3.pe[hps_pkg::PE_W-1]}}, s3.pe})
		  + $signed({{(hps_pkg::P_W-hps_pkg::PD_W){s3.pd[hps_pkg::PD_W-1]}}, s3.pd})
		  + $signed({{(hps_pkg::P_W-hps_pkg::PL_W){s3.pl[hps_pkg::PL_W-1]}}, s3.pl})
		  + $signed({{(hps_pkg::P_W-hps_pkg::PH_W-hps_pkg::SPLIT_W){s3.ph[hps_pkg::PH_W-1]}},
		             s3.ph, {hps_pkg::SPLIT_W{1'b0}}});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= s3_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s3_valid) begin
			p_s4      <= p;
			active_s4 <= s3.active;
			done_s4   <= s3.done;
			steps_s4  <= s3.steps;
		end
	end

	// Shift the magnitude (truncate toward zero), clamp, restore sign
	always_comb begin
		mag    = p_s4[hps_pkg::P_W-1] ? (~p_s4 + 1'b1) : p_s4;
		mag_sh = mag >> hps_pkg::DRIVE_SHIFT;
		if (mag_sh > hps_pkg::P_W'(cfg.max_drive)) begin
			mag_cl = cfg.max_drive;
		end else begin
			mag_cl = mag_sh[hps_pkg::CLAMP_W-1:0];
		end
		if (!active_s4) begin
			drv = '0;
		end else if (p_s4[hps_pkg::P_W-1]) begin
			drv = ~{1'b0, mag_cl} + 1'b1;
		end else begin
			drv = {1'b0, mag_cl};
		end
		res.drive = drv;
		res.done  = done_s4;
		res.steps = steps_s4;
	end

endmodule

// File: hw/rtl/hps_outq.sv
`timescale 1ns / 1ps
// Result queue between the pipeline and the output channel.
// Depends on hps_pkg.
module hps_outq #(
	parameter int DEPTH = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  hps_pkg::res_t push_data,
	input  logic          pop,
	output logic          head_valid,
	output hps_pkg::res_t head
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	hps_pkg::res_t     mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  cnt_q;

	// Write the entry at the tail
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	assign head_valid = (cnt_q != '0);
	assign head       = mem_q[rd_ptr_q];

endmodule

// File: hw/rtl/heading_pid_step.sv
`timescale 1ns / 1ps
// Top level of the heading PID step: config registers, input register, pipeline, queue.
// Depends on hps_pkg, hps_state, hps_mult, hps_sum and hps_outq.
//
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | measured_angle, target_angle, restart
//  out     | out_valid / out_ready| drive, done_res, steps_used
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One beat per cycle while in_ready is high; after the edge that accepts an input beat, it passes
// the input register, state update, products and PID sum into the result queue, which raises out_valid.
// The controller state loop closes within the state update stage, so beats follow back to back.
// in_ready drops once OUTQ_DEPTH beats are outstanding; a stalled output only fills the queue.
// Reset clears controller state, pipeline valids and the queue, and reloads register defaults.
// cfg_ready is always high.
module heading_pid_step #(
	parameter int OUTQ_DEPTH = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,

	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [hps_pkg::ANGLE_W-1:0] measured_angle,
	input  logic signed [hps_pkg::ANGLE_W-1:0] target_angle,
	input  logic                              restart,

	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [hps_pkg::DRIVE_W-1:0] drive,
	output logic                              done_res,
	output logic [hps_pkg::STEP_W-1:0]        steps_used,

	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [hps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [hps_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int OCC_W = $clog2(OUTQ_DEPTH + 1);

	hps_pkg::cfg_t     cfg_q;
	hps_pkg::in_beat_t in_s1;
	logic              valid_s1;
	hps_pkg::step_t    step_s2;
	logic              valid_s2;
	hps_pkg::prod_t    prod_s3;
	logic              valid_s3;
	hps_pkg::res_t     res;
	logic              res_valid;
	hps_pkg::res_t     head;
	logic [OCC_W-1:0]  occ_q;
	logic              in_acc;
	logic              out_acc;

	assign cfg_ready = 1'b1;
	assign in_ready  = (occ_q < OCC_W'(OUTQ_DEPTH));
	assign in_acc    = in_valid & in_ready;
	assign out_acc   = out_valid & out_ready;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain  <= hps_pkg::RST_PROP_GAIN;
			cfg_q.integ_gain <= hps_pkg::RST_INTEG_GAIN;
			cfg_q.deriv_gain <= hps_pkg::RST_DERIV_GAIN;
			cfg_q.max_drive  <= hps_pkg::RST_MAX_DRIVE;
			cfg_q.integ_zone <= hps_pkg::RST_INTEG_ZONE;
			cfg_q.tolerance  <= hps_pkg::RST_TOLERANCE;
			cfg_q.step_limit <= hps_pkg::RST_STEP_LIMIT;
		end else if (cfg_valid) begin
			unique case (hps_pkg::cfg_reg_t'(cfg_index))
				hps_pkg::REG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_data[hps_pkg::GAIN_W-1:0];
				hps_pkg::REG_INTEG_GAIN: cfg_q.integ_gain <= cfg_data[hps_pkg::GAIN_W-1:0];
				hps_pkg::REG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_data[hps_pkg::GAIN_W-1:0];
				hps_pkg::REG_MAX_DRIVE:  cfg_q.max_drive  <= cfg_data[hps_pkg::CLAMP_W-1:0];
				hps_pkg::REG_INTEG_ZONE: cfg_q.integ_zone <= cfg_data[hps_pkg::ZONE_W-1:0];
				hps_pkg::REG_TOLERANCE:  cfg_q.tolerance  <= cfg_data[hps_pkg::ZONE_W-1:0];
				hps_pkg::REG_STEP_LIMIT: cfg_q.step_limit <= cfg_data[hps_pkg::STEP_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			in_s1.measured_angle <= measured_angle;
			in_s1.target_angle   <= target_angle;
			in_s1.restart        <= restart;
		end
	end

	// Count beats accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({in_acc, out_acc})
				2'b10:   occ_q <= occ_q + 1'b1;
				2'b01:   occ_q <= occ_q - 1'b1;
				default: occ_q <= occ_q;
			endcase
		end
	end

	hps_state u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1_valid (valid_s1),
		.s1       (in_s1),
		.cfg      (cfg_q),
		.s2_valid (valid_s2),
		.s2       (step_s2)
	);

	hps_mult u_mult (
		.clk      (clk),
		.arst_n   (arst_n),
		.s2_valid (valid_s2),
		.s2       (step_s2),
		.cfg      (cfg_q),
		.s3_valid (valid_s3),
		.s3       (prod_s3)
	);

	hps_sum u_sum (
		.clk       (clk),
		.arst_n    (arst_n),
		.s3_valid  (valid_s3),
		.s3        (prod_s3),
		.cfg       (cfg_q),
		.res_valid (res_valid),
		.res       (res)
	);

	hps_outq #(
		.DEPTH (OUTQ_DEPTH)
	) u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (res_valid),
		.push_data  (res),
		.pop        (out_acc),
		.head_valid (out_valid),
		.head       (head)
	);

	assign drive      = head.drive;
	assign done_res   = head.done;
	assign steps_used = head.steps;

`ifndef SYNTHESIS
	// Outstanding beats never exceed the queue size
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(OUTQ_DEPTH))
		else $error("outstanding beat count above queue depth");

	// A result on the port must belong to an outstanding beat
	a_out_owned: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (occ_q != '0))
		else $error("result presented with no outstanding beat");

	// A finished turn always brakes
	a_done_brake: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && done_res) |-> (drive == '0))
		else $error("nonzero drive on a finished turn");

	// An accepted beat is counted on the next edge
	a_acc_counted: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (occ_q != '0))
		else $error("accepted beat not counted");
`endif

endmodule
